@@ hw/rtl/bfsa_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bfsa_pkg
// Shared types and codes for the best-fit segment allocator: transfer
// payloads, status codes, opcodes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package bfsa_pkg;

   localparam int DW = 32;

   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_INIT  = 2'd2;

   localparam logic [3:0]  MAX_ALIGN_LOG2 = 4'd12;
   localparam logic [31:0] REGION_RESET   = 32'd1048576;
   localparam logic [2:0]  REG_REGION_ADDR = 3'd0;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_OOM     = 3'd1,
      ST_DOUBLE  = 3'd2,
      ST_UNKNOWN = 3'd3,
      ST_FULL    = 3'd4,
      ST_BAD     = 3'd5
   } status_type;

   typedef struct packed {
      logic [1:0]    opcode;
      logic [DW-1:0] request_bytes;
      logic [3:0]    align_log2;
      logic [DW-1:0] free_address;
   } req_type;

   typedef struct packed {
      logic [2:0]    status;
      logic [DW-1:0] data_address;
      logic [DW-1:0] granted_bytes;
      logic [DW-1:0] used_bytes;
   } rsp_type;

   typedef struct packed {
      logic       capture;
      logic       init;
      logic       decode;
      logic       scan_start;
      logic       fscan;
      logic       ascan_start;
      logic       ascan;
      logic       commit;
      logic       shift;
      logic       final_step;
      logic       set_st;
      status_type st;
   } ctl_cmd_type;

   typedef struct packed {
      logic is_alloc;
      logic is_free;
      logic is_init;
      logic alloc_bad;
      logic free_bad;
      logic fscan_done;
      logic best_found;
      logic dbl;
      logic ascan_done;
      logic ascan_hit;
      logic fr_full;
      logic shift_done;
   } ctl_stat_type;

endpackage
`default_nettype wire

@@ hw/rtl/best_fit_segment_allocator_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// best_fit_segment_allocator_top
// Best-fit allocator over a byte region with an address-sorted free table.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_stall/req_payload) carries one command per
//   transfer: allocate, free or init. rsp channel returns exactly one result
//   per command: status, data address, granted bytes and bytes in use.
//   Region size is set through the APB register at address 0 and is taken by
//   the next init command.
// Sequence:
//   one command at a time. A command is decoded, scans the free table and
//   then the allocation table, commits, moves free table entries on insert
//   or removal and hands off its result. Error cases end early. Each scan
//   reads its table through the single read port of that table RAM.
// Reset:
//   the boot state loads the whole region as a single free segment and
//   clears the allocation table. req_stall is high while a command works.
//   A result waits in the output register while rsp_stall is high; the next
//   command is still taken meanwhile, but its own result waits for that slot.
// ----------------------------------------------------------------------------
module best_fit_segment_allocator_top #(
   parameter int MAX_FREE     = 64,
   parameter int MAX_ALLOCS   = 64,
   parameter int HEADER_BYTES = 16,
   parameter int ADDR_BITS    = 32
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  var bfsa_pkg::req_type  req_payload,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output bfsa_pkg::rsp_type      rsp_payload,
   input  wire                    psel,
   input  wire                    penable,
   input  wire                    pwrite,
   input  wire  [2:0]             paddr,
   input  wire  [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   bfsa_pkg::ctl_cmd_type  cmd;
   bfsa_pkg::ctl_stat_type stat;
   bfsa_pkg::rsp_type      res;

   logic [31:0]       region_ff, region_in;
   logic              rsp_valid_ff, rsp_valid_in;
   bfsa_pkg::rsp_type rsp_payload_ff, rsp_payload_in;
   logic              out_free;
   logic              out_load;
   logic              reg_hit;

   assign reg_hit = (paddr == bfsa_pkg::REG_REGION_ADDR);
   assign pready  = 1'b1;
   assign prdata  = reg_hit ? region_ff : 32'd0;

   always_comb begin
      region_in = region_ff;
      if (psel && penable && pwrite && reg_hit) begin
         region_in = pwdata;
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (out_load) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = res;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_ff    <= bfsa_pkg::REGION_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         region_ff    <= region_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   bfsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .out_free  (out_free),
      .out_load  (out_load),
      .stat      (stat),
      .cmd       (cmd)
   );

   bfsa_dpath #(
      .MAX_FREE     (MAX_FREE),
      .MAX_ALLOCS   (MAX_ALLOCS),
      .HEADER_BYTES (HEADER_BYTES),
      .ADDR_BITS    (ADDR_BITS)
   ) u_dpath (
      .clock  (clock),
      .reset  (reset),
      .region (region_ff),
      .req    (req_payload),
      .cmd    (cmd),
      .stat   (stat),
      .res    (res)
   );

endmodule
`default_nettype wire

@@ hw/rtl/bfsa_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bfsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfsa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire                                       clock,
   input  wire                                       we,
   input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire  [WIDTH-1:0]                          wdata,
   input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

@@ hw/rtl/bfsa_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bfsa_ctrl
// Sequencer for the allocator: walks each request through decode, free
// table scan, allocation table scan, commit, table shift and response.
// ----------------------------------------------------------------------------
module bfsa_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   input  wire                     out_free,
   output logic                    out_load,
   input  var bfsa_pkg::ctl_stat_type stat,
   output bfsa_pkg::ctl_cmd_type   cmd
);

   typedef enum logic [8:0] {
      S_BOOT   = 9'b000000001,
      S_IDLE   = 9'b000000010,
      S_DECODE = 9'b000000100,
      S_FSCAN  = 9'b000001000,
      S_ASCAN  = 9'b000010000,
      S_COMMIT = 9'b000100000,
      S_SHIFT  = 9'b001000000,
      S_FINAL  = 9'b010000000,
      S_RESP   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.st    = bfsa_pkg::ST_OK;
      req_stall = 1'b1;
      out_load  = 1'b0;
      unique case (state_ff)
         S_BOOT: begin
            cmd.init = 1'b1;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            if (stat.is_init) begin
               cmd.init   = 1'b1;
               cmd.set_st = 1'b1;
               cmd.st     = bfsa_pkg::ST_OK;
               state_in   = S_RESP;
            end else if (stat.is_alloc && !stat.alloc_bad) begin
               cmd.scan_start = 1'b1;
               state_in       = S_FSCAN;
            end else if (stat.is_free && !stat.free_bad) begin
               cmd.scan_start = 1'b1;
               state_in       = S_FSCAN;
            end else begin
               cmd.set_st = 1'b1;
               cmd.st     = stat.is_free ? bfsa_pkg::ST_UNKNOWN : bfsa_pkg::ST_BAD;
               state_in   = S_RESP;
            end
         end
         S_FSCAN: begin
            cmd.fscan = 1'b1;
            if (stat.fscan_done) begin
               if (stat.is_alloc && !stat.best_found) begin
                  cmd.set_st = 1'b1;
                  cmd.st     = bfsa_pkg::ST_OOM;
                  state_in   = S_RESP;
               end else if (stat.is_free && stat.dbl) begin
                  cmd.set_st = 1'b1;
                  cmd.st     = bfsa_pkg::ST_DOUBLE;
                  state_in   = S_RESP;
               end else begin
                  cmd.ascan_start = 1'b1;
                  state_in        = S_ASCAN;
               end
            end
         end
         S_ASCAN: begin
            cmd.ascan = 1'b1;
            if (stat.ascan_done) begin
               if (stat.ascan_hit) begin
                  state_in = S_COMMIT;
               end else begin
                  cmd.set_st = 1'b1;
                  cmd.st     = stat.is_alloc ? bfsa_pkg::ST_FULL : bfsa_pkg::ST_UNKNOWN;
                  state_in   = S_RESP;
               end
            end
         end
         S_COMMIT: begin
            if (stat.is_free && stat.fr_full) begin
               cmd.set_st = 1'b1;
               cmd.st     = bfsa_pkg::ST_FULL;
               state_in   = S_RESP;
            end else begin
               cmd.commit = 1'b1;
               state_in   = S_SHIFT;
            end
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            if (stat.shift_done) begin
               state_in = S_FINAL;
            end
         end
         S_FINAL: begin
            cmd.final_step = 1'b1;
            state_in       = S_RESP;
         end
         S_RESP: begin
            out_load = out_free;
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_BOOT;
      end else begin
         state_ff <= state_in;
      end
   end

   // a transfer is only taken from idle and always leads to decode
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == S_DECODE)
      else $error("request taken outside idle");

   // a result is loaded only when the output register can take it
   assert property (@(posedge clock) disable iff (reset)
      out_load |-> state_ff == S_RESP && out_free)
      else $error("result loaded into busy output register");

   assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("controller state not one-hot");

endmodule
`default_nettype wire

@@ hw/rtl/bfsa_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bfsa_dpath
// Allocator datapath: free segment table and allocation table in RAM,
// scan registers, commit arithmetic, table shifter and result registers.
// ----------------------------------------------------------------------------
module bfsa_dpath #(
   parameter int MAX_FREE     = 64,
   parameter int MAX_ALLOCS   = 64,
   parameter int HEADER_BYTES = 16,
   parameter int ADDR_BITS    = 32
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire  [31:0]               region,
   input  var bfsa_pkg::req_type     req,
   input  var bfsa_pkg::ctl_cmd_type cmd,
   output bfsa_pkg::ctl_stat_type    stat,
   output bfsa_pkg::rsp_type         res
);
   localparam int FIW = $clog2(MAX_FREE);
   localparam int CW  = $clog2(MAX_FREE + 1);
   localparam int AIW = (MAX_ALLOCS > 1) ? $clog2(MAX_ALLOCS) : 1;
   localparam int ACW = $clog2(MAX_ALLOCS + 1);
   localparam logic [CW-1:0]  FREE_LIM  = CW'(MAX_FREE);
   localparam logic [ACW-1:0] ALLOC_LIM = ACW'(MAX_ALLOCS);
   localparam logic [31:0]    HDR       = 32'(HEADER_BYTES);
   localparam logic [63:0]    ADDR_CAP  = (64'd1 << ADDR_BITS) - 64'd1;

   // captured request
   logic [1:0]  op_ff, op_in;
   logic [31:0] rq_ff, rq_in;
   logic [3:0]  al_ff, al_in;
   logic [31:0] addr_ff, addr_in;
   logic [33:0] need_ff, need_in;

   // table state
   logic [CW-1:0]         count_ff, count_in;
   logic [31:0]           used_ff, used_in;
   logic [MAX_ALLOCS-1:0] valid_ff, valid_in;

   // free table scan
   logic [CW-1:0]  rp_ff, rp_in;
   logic           pend_ff, pend_in;
   logic [FIW-1:0] idx_ff, idx_in;
   logic           best_found_ff, best_found_in;
   logic [FIW-1:0] best_idx_ff, best_idx_in;
   logic [31:0]    best_start_ff, best_start_in;
   logic [31:0]    best_size_ff, best_size_in;
   logic           dbl_ff, dbl_in;
   logic           p_found_ff, p_found_in;
   logic [FIW-1:0] p_idx_ff, p_idx_in;
   logic [31:0]    next_start_ff, next_start_in;
   logic [31:0]    next_size_ff, next_size_in;
   logic           prev_valid_ff, prev_valid_in;
   logic [FIW-1:0] prev_idx_ff, prev_idx_in;
   logic [31:0]    prev_start_ff, prev_start_in;
   logic [31:0]    prev_size_ff, prev_size_in;

   // allocation table scan
   logic [ACW-1:0] aj_ff, aj_in;
   logic           apend_ff, apend_in;
   logic [AIW-1:0] aidx_ff, aidx_in;
   logic           hit_ff, hit_in;
   logic [AIW-1:0] slot_ff, slot_in;
   logic [31:0]    slot_size_ff, slot_size_in;

   // shifter and final step
   logic [CW-1:0]  sh_rp_ff, sh_rp_in;
   logic [CW-1:0]  sh_lim_ff, sh_lim_in;
   logic           sh_up_ff, sh_up_in;
   logic           sh_pend_ff, sh_pend_in;
   logic [FIW-1:0] sh_wa_ff, sh_wa_in;
   logic           fin_ins_ff, fin_ins_in;
   logic           fin_dec_ff, fin_dec_in;

   // result
   bfsa_pkg::status_type res_st_ff, res_st_in;
   logic [31:0]          res_da_ff, res_da_in;
   logic [31:0]          res_gb_ff, res_gb_in;

   // memories
   logic           fr_we;
   logic [FIW-1:0] fr_waddr, fr_raddr;
   logic [63:0]    fr_wdata, fr_rdata;
   logic           ar_we;
   logic [AIW-1:0] ar_waddr, ar_raddr;
   logic [63:0]    ar_wdata, ar_rdata;

   // combinational helpers
   logic [31:0]   region_sat;
   logic [12:0]   gran;
   logic [33:0]   need_sum;
   logic [33:0]   need_calc;
   logic [31:0]   seg;
   logic [31:0]   rs, rz;
   logic          is_alloc, is_free;
   logic          hit_now;
   logic          jn, jp;
   logic [CW-1:0] p_eff;
   logic [31:0]   left;
   logic          split;
   logic [31:0]   grant;

   bfsa_ram #(.WIDTH(64), .DEPTH(MAX_FREE)) u_free_ram (
      .clock (clock),
      .we    (fr_we),
      .waddr (fr_waddr),
      .wdata (fr_wdata),
      .raddr (fr_raddr),
      .rdata (fr_rdata)
   );

   bfsa_ram #(.WIDTH(64), .DEPTH(MAX_ALLOCS)) u_alloc_ram (
      .clock (clock),
      .we    (ar_we),
      .waddr (ar_waddr),
      .wdata (ar_wdata),
      .raddr (ar_raddr),
      .rdata (ar_rdata)
   );

   assign region_sat = ({32'd0, region} > ADDR_CAP) ? ADDR_CAP[31:0] : region;
   assign gran       = 13'd1 << al_ff;
   assign need_sum   = {2'b00, rq_ff} + 34'(HEADER_BYTES) + {21'd0, gran} - 34'd1;
   assign need_calc  = need_sum & ~({21'd0, gran} - 34'd1);
   assign seg        = addr_ff - HDR;
   assign rs         = fr_rdata[63:32];
   assign rz         = fr_rdata[31:0];
   assign is_alloc   = (op_ff == bfsa_pkg::OP_ALLOC);
   assign is_free    = (op_ff == bfsa_pkg::OP_FREE);

   assign hit_now = apend_ff && (is_alloc ? !valid_ff[aidx_ff]
                                          : (valid_ff[aidx_ff] && ar_rdata[63:32] == seg));

   assign jn = p_found_ff && ({1'b0, seg} + {1'b0, slot_size_ff}) == {1'b0, next_start_ff};
   assign jp = prev_valid_ff && ({1'b0, prev_start_ff} + {1'b0, prev_size_ff}) == {1'b0, seg};
   assign p_eff = p_found_ff ? CW'(p_idx_ff) : count_ff;

   assign left  = best_size_ff - need_ff[31:0];
   assign split = left > HDR;
   assign grant = split ? need_ff[31:0] : best_size_ff;

   always_comb begin
      op_in         = op_ff;
      rq_in         = rq_ff;
      al_in         = al_ff;
      addr_in       = addr_ff;
      need_in       = need_ff;
      count_in      = count_ff;
      used_in       = used_ff;
      valid_in      = valid_ff;
      rp_in         = rp_ff;
      pend_in       = pend_ff;
      idx_in        = idx_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_start_in = best_start_ff;
      best_size_in  = best_size_ff;
      dbl_in        = dbl_ff;
      p_found_in    = p_found_ff;
      p_idx_in      = p_idx_ff;
      next_start_in = next_start_ff;
      next_size_in  = next_size_ff;
      prev_valid_in = prev_valid_ff;
      prev_idx_in   = prev_idx_ff;
      prev_start_in = prev_start_ff;
      prev_size_in  = prev_size_ff;
      aj_in         = aj_ff;
      apend_in      = apend_ff;
      aidx_in       = aidx_ff;
      hit_in        = hit_ff;
      slot_in       = slot_ff;
      slot_size_in  = slot_size_ff;
      sh_rp_in      = sh_rp_ff;
      sh_lim_in     = sh_lim_ff;
      sh_up_in      = sh_up_ff;
      sh_pend_in    = sh_pend_ff;
      sh_wa_in      = sh_wa_ff;
      fin_ins_in    = fin_ins_ff;
      fin_dec_in    = fin_dec_ff;
      res_st_in     = res_st_ff;
      res_da_in     = res_da_ff;
      res_gb_in     = res_gb_ff;
      fr_we         = 1'b0;
      fr_waddr      = '0;
      fr_wdata      = '0;
      fr_raddr      = '0;
      ar_we         = 1'b0;
      ar_waddr      = '0;
      ar_wdata      = '0;
      ar_raddr      = '0;

      if (cmd.capture) begin
         op_in   = req.opcode;
         rq_in   = req.request_bytes;
         al_in   = req.align_log2;
         addr_in = req.free_address;
      end

      if (cmd.decode) begin
         need_in = need_calc;
      end

      if (cmd.init) begin
         fr_we    = 1'b1;
         fr_waddr = '0;
         fr_wdata = {32'd0, region_sat};
         count_in = CW'(1);
         valid_in = '0;
         used_in  = '0;
      end

      if (cmd.scan_start) begin
         rp_in         = '0;
         pend_in       = 1'b0;
         best_found_in = 1'b0;
         dbl_in        = 1'b0;
         p_found_in    = 1'b0;
         prev_valid_in = 1'b0;
      end

      // one table entry read per cycle, compared the cycle after
      if (cmd.fscan) begin
         pend_in = 1'b0;
         if (rp_ff < count_ff) begin
            fr_raddr = rp_ff[FIW-1:0];
            pend_in  = 1'b1;
            idx_in   = rp_ff[FIW-1:0];
            rp_in    = rp_ff + CW'(1);
         end
         if (pend_ff) begin
            if (is_alloc) begin
               if ({2'b00, rz} >= need_ff && (!best_found_ff || rz <= best_size_ff)) begin
                  best_found_in = 1'b1;
                  best_idx_in   = idx_ff;
                  best_start_in = rs;
                  best_size_in  = rz;
               end
            end else begin
               if (seg >= rs && (seg - rs) < rz) begin
                  dbl_in = 1'b1;
               end
               if (rs > seg) begin
                  if (!p_found_ff) begin
                     p_found_in    = 1'b1;
                     p_idx_in      = idx_ff;
                     next_start_in = rs;
                     next_size_in  = rz;
                  end
               end else begin
                  prev_valid_in = 1'b1;
                  prev_idx_in   = idx_ff;
                  prev_start_in = rs;
                  prev_size_in  = rz;
               end
            end
         end
      end

      if (cmd.ascan_start) begin
         aj_in    = '0;
         apend_in = 1'b0;
         hit_in   = 1'b0;
      end

      if (cmd.ascan) begin
         apend_in = 1'b0;
         if (hit_now && !hit_ff) begin
            hit_in       = 1'b1;
            slot_in      = aidx_ff;
            slot_size_in = ar_rdata[31:0];
         end
         if (!hit_ff && !hit_now && aj_ff < ALLOC_LIM) begin
            ar_raddr = aj_ff[AIW-1:0];
            apend_in = 1'b1;
            aidx_in  = aj_ff[AIW-1:0];
            aj_in    = aj_ff + ACW'(1);
         end
      end

      if (cmd.commit) begin
         sh_pend_in = 1'b0;
         sh_up_in   = 1'b0;
         sh_rp_in   = count_ff;
         sh_lim_in  = count_ff;
         fin_ins_in = 1'b0;
         fin_dec_in = 1'b0;
         res_st_in  = bfsa_pkg::ST_OK;
         if (is_alloc) begin
            if (split) begin
               fr_we    = 1'b1;
               fr_waddr = best_idx_ff;
               fr_wdata = {best_start_ff + need_ff[31:0], left};
            end else begin
               // whole segment granted, close the gap in the table
               sh_rp_in   = CW'(best_idx_ff) + CW'(1);
               fin_dec_in = 1'b1;
            end
            ar_we          = 1'b1;
            ar_waddr       = slot_ff;
            ar_wdata       = {best_start_ff, grant};
            valid_in[slot_ff] = 1'b1;
            used_in        = used_ff + grant;
            res_da_in      = best_start_ff + HDR;
            res_gb_in      = grant;
         end else begin
            if (jp && jn) begin
               fr_we      = 1'b1;
               fr_waddr   = prev_idx_ff;
               fr_wdata   = {prev_start_ff, prev_size_ff + slot_size_ff + next_size_ff};
               sh_rp_in   = p_eff + CW'(1);
               fin_dec_in = 1'b1;
            end else if (jp) begin
               fr_we    = 1'b1;
               fr_waddr = prev_idx_ff;
               fr_wdata = {prev_start_ff, prev_size_ff + slot_size_ff};
            end else if (jn) begin
               fr_we    = 1'b1;
               fr_waddr = p_idx_ff;
               fr_wdata = {seg, next_size_ff + slot_size_ff};
            end else begin
               // open a hole at the insert point, filled in the final step
               sh_up_in   = 1'b1;
               sh_lim_in  = p_eff;
               fin_ins_in = 1'b1;
            end
            valid_in[slot_ff] = 1'b0;
            used_in   = (slot_size_ff <= used_ff) ? used_ff - slot_size_ff : '0;
            res_da_in = addr_ff;
            res_gb_in = slot_size_ff;
         end
      end

      if (cmd.shift) begin
         sh_pend_in = 1'b0;
         if (sh_pend_ff) begin
            fr_we    = 1'b1;
            fr_waddr = sh_wa_ff;
            fr_wdata = fr_rdata;
         end
         if (!sh_up_ff && sh_rp_ff < sh_lim_ff) begin
            fr_raddr   = sh_rp_ff[FIW-1:0];
            sh_wa_in   = FIW'(sh_rp_ff - CW'(1));
            sh_pend_in = 1'b1;
            sh_rp_in   = sh_rp_ff + CW'(1);
         end else if (sh_up_ff && sh_rp_ff > sh_lim_ff) begin
            fr_raddr   = FIW'(sh_rp_ff - CW'(1));
            sh_wa_in   = sh_rp_ff[FIW-1:0];
            sh_pend_in = 1'b1;
            sh_rp_in   = sh_rp_ff - CW'(1);
         end
      end

      if (cmd.final_step) begin
         if (fin_ins_ff) begin
            fr_we    = 1'b1;
            fr_waddr = p_eff[FIW-1:0];
            fr_wdata = {seg, slot_size_ff};
            count_in = count_ff + CW'(1);
         end
         if (fin_dec_ff) begin
            count_in = count_ff - CW'(1);
         end
         fin_ins_in = 1'b0;
         fin_dec_in = 1'b0;
      end

      if (cmd.set_st) begin
         res_st_in = cmd.st;
         res_da_in = '0;
         res_gb_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= CW'(1);
         used_ff       <= '0;
         valid_ff      <= '0;
         rp_ff         <= '0;
         pend_ff       <= 1'b0;
         best_found_ff <= 1'b0;
         dbl_ff        <= 1'b0;
         p_found_ff    <= 1'b0;
         prev_valid_ff <= 1'b0;
         aj_ff         <= '0;
         apend_ff      <= 1'b0;
         hit_ff        <= 1'b0;
         sh_rp_ff      <= '0;
         sh_lim_ff     <= '0;
         sh_up_ff      <= 1'b0;
         sh_pend_ff    <= 1'b0;
         fin_ins_ff    <= 1'b0;
         fin_dec_ff    <= 1'b0;
         res_st_ff     <= bfsa_pkg::ST_OK;
      end else begin
         count_ff      <= count_in;
         used_ff       <= used_in;
         valid_ff      <= valid_in;
         rp_ff         <= rp_in;
         pend_ff       <= pend_in;
         best_found_ff <= best_found_in;
         dbl_ff        <= dbl_in;
         p_found_ff    <= p_found_in;
         prev_valid_ff <= prev_valid_in;
         aj_ff         <= aj_in;
         apend_ff      <= apend_in;
         hit_ff        <= hit_in;
         sh_rp_ff      <= sh_rp_in;
         sh_lim_ff     <= sh_lim_in;
         sh_up_ff      <= sh_up_in;
         sh_pend_ff    <= sh_pend_in;
         fin_ins_ff    <= fin_ins_in;
         fin_dec_ff    <= fin_dec_in;
         res_st_ff     <= res_st_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      rq_ff         <= rq_in;
      al_ff         <= al_in;
      addr_ff       <= addr_in;
      need_ff       <= need_in;
      idx_ff        <= idx_in;
      best_idx_ff   <= best_idx_in;
      best_start_ff <= best_start_in;
      best_size_ff  <= best_size_in;
      p_idx_ff      <= p_idx_in;
      next_start_ff <= next_start_in;
      next_size_ff  <= next_size_in;
      prev_idx_ff   <= prev_idx_in;
      prev_start_ff <= prev_start_in;
      prev_size_ff  <= prev_size_in;
      aidx_ff       <= aidx_in;
      slot_ff       <= slot_in;
      slot_size_ff  <= slot_size_in;
      sh_wa_ff      <= sh_wa_in;
      res_da_ff     <= res_da_in;
      res_gb_ff     <= res_gb_in;
   end

   always_comb begin
      stat            = '0;
      stat.is_alloc   = is_alloc;
      stat.is_free    = is_free;
      stat.is_init    = (op_ff == bfsa_pkg::OP_INIT);
      stat.alloc_bad  = (rq_ff == '0) || (al_ff > bfsa_pkg::MAX_ALIGN_LOG2);
      stat.free_bad   = addr_ff < HDR;
      stat.fscan_done = !pend_ff && (rp_ff >= count_ff);
      stat.best_found = best_found_ff;
      stat.dbl        = dbl_ff;
      stat.ascan_done = hit_ff || (!apend_ff && aj_ff >= ALLOC_LIM);
      stat.ascan_hit  = hit_ff;
      stat.fr_full    = !jn && !jp && (count_ff >= FREE_LIM);
      stat.shift_done = !sh_pend_ff && (sh_up_ff ? (sh_rp_ff <= sh_lim_ff)
                                                 : (sh_rp_ff >= sh_lim_ff));
   end

   assign res.status        = res_st_ff;
   assign res.data_address  = res_da_ff;
   assign res.granted_bytes = res_gb_ff;
   assign res.used_bytes    = used_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= FREE_LIM)
      else $error("free table count beyond capacity");

   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> hit_ff && (!is_alloc || best_found_ff))
      else $error("commit without a slot or a fitting segment");

   assert property (@(posedge clock) disable iff (reset)
      cmd.commit && is_free |-> !dbl_ff && !stat.fr_full)
      else $error("free committed over a double free or a full table");

endmodule
`default_nettype wire
